// ===== rtl/core/rclpf_pkg.sv =====
`default_nettype none

package rclpf_pkg;

   // Scaling of the channel values
   localparam int FULL_SCALE   = 10000;
   localparam int NUM_CHANNELS = 7;
   localparam int SPAN         = 640;

   // Field widths
   localparam int CH_W   = 16;
   localparam int MAG_W  = CH_W + 1;
   localparam int VAL_W  = 10;
   localparam int FS_W   = 15;
   // |channel| * SPAN stays below 2**25
   localparam int M_W    = 25;
   localparam int PROD_W = 2 * M_W + 1;
   localparam int BACK_W = M_W + FS_W;

   // Reciprocal of the full scale: estimate is exact or one low
   localparam logic [M_W:0] RECIP = (M_W + 1)'((64'd1 << M_W) / FULL_SCALE);

   // Register stages of one scaling lane
   localparam int LANE_STAGES = 4;

   // Packet lengths and emit index
   localparam int DATA_LEN = 20;
   localparam int BIND_LEN = 12;
   localparam int IDX_W    = 5;

   // Commands
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_BIND = 1'b1;

   // Packet constants
   localparam logic [7:0]  DATA_HDR     = 8'h13;
   localparam logic [7:0]  BIND_HDR     = 8'h0b;
   localparam logic [7:0]  PKT_VER      = 8'h01;
   localparam logic [7:0]  BIND_MARK    = 8'h7d;
   localparam logic [7:0]  BIND_TAIL_HI = 8'hc5;
   localparam logic [7:0]  BIND_TAIL_LO = 8'hd6;
   localparam logic [15:0] DATA_SYNC    = 16'h2f4a;
   localparam logic [15:0] BIND_SYNC    = 16'h7d7d;
   localparam logic [31:0] TX_ID_RESET  = 32'hb2c54a2f;

   typedef logic [DATA_LEN-1:0][7:0] frame_type;
   typedef logic [NUM_CHANNELS-1:0][VAL_W-1:0] lane_vals_type;
   typedef logic signed [CH_W-1:0] channel_type;

   // Emitter status toward the request side
   typedef struct packed {
      logic active;
      logic at_last;
      logic drain_ok;
   } emit_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/rclpf_scale_lane.sv =====
`default_nettype none

module rclpf_scale_lane import rclpf_pkg::*; (
   input  wire logic             clock,
   input  wire channel_type      channel,
   output logic [VAL_W-1:0]      value
);

   logic signed [MAG_W-1:0] ext;
   logic [MAG_W-1:0]        mag;
   logic [M_W-1:0]          m_in, m_ff, m2_ff;
   logic                    neg_ff, neg2_ff, neg3_ff;
   logic [PROD_W-1:0]       prod;
   logic [M_W-1:0]          q_est_ff;
   logic [BACK_W-1:0]       back;
   logic [M_W-1:0]          rem;
   logic [M_W-1:0]          q_in, q_ff;
   logic [VAL_W-1:0]        value_in, value_ff;

   // Stage 1: take magnitude and scale by the span
   always_comb begin
      ext  = {channel[CH_W-1], channel};
      mag  = ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
      m_in = M_W'((MAG_W + VAL_W)'(mag) * (MAG_W + VAL_W)'(SPAN));
   end

   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      neg_ff <= channel[CH_W-1];
   end

   // Stage 2: estimate quotient by reciprocal multiply
   assign prod = PROD_W'(m_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      q_est_ff <= prod[M_W +: M_W];
      m2_ff    <= m_ff;
      neg2_ff  <= neg_ff;
   end

   // Stage 3: correct the estimate by one where the remainder is too large
   always_comb begin
      back = BACK_W'(q_est_ff) * BACK_W'(FULL_SCALE);
      rem  = m2_ff - back[M_W-1:0];
      q_in = (rem >= M_W'(FULL_SCALE)) ? q_est_ff + M_W'(1) : q_est_ff;
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      neg3_ff <= neg2_ff;
   end

   // Stage 4: offset by the span and clamp to 0..span
   always_comb begin
      if (!neg3_ff) begin
         value_in = VAL_W'(SPAN);
      end else if (q_ff >= M_W'(SPAN)) begin
         value_in = '0;
      end else begin
         value_in = VAL_W'(SPAN) - q_ff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rclpf_frame_merge.sv =====
`default_nettype none

module rclpf_frame_merge import rclpf_pkg::*; (
   input  wire logic          command,
   input  wire lane_vals_type vals,
   input  wire logic [31:0]   tx_id,
   output frame_type          frame
);

   logic [7:0] x1;
   logic [7:0] x2;
   logic [7:0] sum_hi;
   frame_type  data;

   // Pack lane values behind the header and append the check bytes
   always_comb begin
      data    = '0;
      data[0] = DATA_HDR;
      data[1] = tx_id[23:16];
      data[2] = PKT_VER;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         data[3 + 2 * i] = 8'(vals[i] >> 8);
         data[4 + 2 * i] = vals[i][7:0];
      end
      x1     = '0;
      x2     = '0;
      sum_hi = '0;
      for (int i = 3; i <= 16; i++) begin
         x1 = x1 ^ data[i];
      end
      for (int i = 3; i <= 14; i++) begin
         x2 = x2 ^ data[i];
      end
      for (int i = 3; i <= 13; i += 2) begin
         sum_hi = sum_hi + data[i];
      end
      data[17] = x1;
      data[18] = x2;
      data[19] = sum_hi;
   end

   // Select data or fixed bind layout
   always_comb begin
      if (command == CMD_BIND) begin
         frame     = '0;
         frame[0]  = BIND_HDR;
         frame[1]  = BIND_MARK;
         frame[2]  = PKT_VER;
         frame[3]  = PKT_VER;
         frame[4]  = tx_id[31:24];
         frame[5]  = tx_id[23:16];
         frame[6]  = tx_id[15:8];
         frame[7]  = tx_id[7:0];
         frame[10] = BIND_TAIL_HI;
         frame[11] = BIND_TAIL_LO;
      end else begin
         frame = data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rclpf_emitter.sv =====
`default_nettype none

module rclpf_emitter import rclpf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic        load_cmd,
   input  wire frame_type   frame,
   input  wire logic [31:0] tx_id,
   output emit_status_type  status,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte,
   output logic [15:0]      rsp_sync_word,
   output logic [7:0]       rsp_radio_address,
   output logic [7:0]       rsp_radio_channel
);

   frame_type        store_ff;
   logic             active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             bind_ff;
   logic [15:0]      sync_ff;
   logic [7:0]       addr_ff;
   logic [7:0]       chan_ff;
   logic [IDX_W-1:0] last_idx;
   logic             at_last;

   assign last_idx = bind_ff ? IDX_W'(BIND_LEN - 1) : IDX_W'(DATA_LEN - 1);
   assign at_last  = (idx_ff == last_idx);

   // Advance the emit index one beat per cycle, restart on load
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (load) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (active_ff) begin
         if (at_last) begin
            active_in = 1'b0;
            idx_in    = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   // Capture the packet and its radio settings on load
   always_ff @(posedge clock) begin
      if (load) begin
         store_ff <= frame;
         bind_ff  <= (load_cmd == CMD_BIND);
         if (load_cmd == CMD_BIND) begin
            sync_ff <= BIND_SYNC;
            addr_ff <= BIND_MARK;
            chan_ff <= BIND_MARK;
         end else begin
            sync_ff <= DATA_SYNC;
            addr_ff <= tx_id[23:16];
            chan_ff <= tx_id[31:24];
         end
      end
   end

   // Report whether the packet ends no later than a new one leaves the lanes
   always_comb begin
      status.active   = active_ff;
      status.at_last  = at_last;
      status.drain_ok = ((IDX_W + 1)'(idx_ff) + (IDX_W + 1)'(LANE_STAGES))
                        >= (IDX_W + 1)'(last_idx);
   end

   assign rsp_strobe        = active_ff;
   assign rsp_out_byte      = store_ff[idx_ff];
   assign rsp_last_byte     = active_ff & at_last;
   assign rsp_sync_word     = sync_ff;
   assign rsp_radio_address = addr_ff;
   assign rsp_radio_channel = chan_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rc_link_packet_framer.sv =====
// Radio link packet framer. A request (start high while busy is low) builds
// one packet: a data request scales seven signed channel values in seven
// parallel four-stage lanes and emits 20 bytes, a bind request emits 12
// fixed bytes carrying the transmitter id. Bytes leave one per cycle, one
// beat per cycle on rsp_strobe, and the receiver cannot stall them. The
// first byte appears once the request has passed the lane stages and been
// loaded into the emitter. The one-byte-per-cycle emitter sets the rate, and
// the next request is taken while the current packet is still going out,
// so packets follow with no gap. Write csr_wr_data only while the block is
// idle.
`default_nettype none

module rc_link_packet_framer import rclpf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire channel_type req_channel_0,
   input  wire channel_type req_channel_1,
   input  wire channel_type req_channel_2,
   input  wire channel_type req_channel_3,
   input  wire channel_type req_channel_4,
   input  wire channel_type req_channel_5,
   input  wire channel_type req_channel_6,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte,
   output logic [15:0]      rsp_sync_word,
   output logic [7:0]       rsp_radio_address,
   output logic [7:0]       rsp_radio_channel
);

   logic [31:0]            tx_id_ff;
   logic                   accept;
   logic [LANE_STAGES-1:0] vld_ff, vld_in;
   logic [LANE_STAGES-1:0] cmd_ff, cmd_in;
   channel_type            chans [NUM_CHANNELS];
   lane_vals_type          vals;
   frame_type              frame;
   emit_status_type        status;
   logic                   load;

   // Hold the transmitter id
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_id_ff <= TX_ID_RESET;
      end else if (csr_wr_en) begin
         tx_id_ff <= csr_wr_data;
      end
   end

   // Take a request only when its packet can start as the current one ends
   assign busy   = (|vld_ff) | (status.active & ~status.drain_ok);
   assign accept = start & ~busy;

   // Track the beat through the lane stages
   assign vld_in = {vld_ff[LANE_STAGES-2:0], accept};
   assign cmd_in = {cmd_ff[LANE_STAGES-2:0], req_command};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign load = vld_ff[LANE_STAGES-1];

   // Scale each channel in its own lane
   assign chans[0] = req_channel_0;
   assign chans[1] = req_channel_1;
   assign chans[2] = req_channel_2;
   assign chans[3] = req_channel_3;
   assign chans[4] = req_channel_4;
   assign chans[5] = req_channel_5;
   assign chans[6] = req_channel_6;

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      rclpf_scale_lane u_lane (
         .clock   (clock),
         .channel (chans[g]),
         .value   (vals[g])
      );
   end

   // Merge lane results into the packet
   rclpf_frame_merge u_merge (
      .command (cmd_ff[LANE_STAGES-1]),
      .vals    (vals),
      .tx_id   (tx_id_ff),
      .frame   (frame)
   );

   // Emit the packet bytes
   rclpf_emitter u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .load_cmd          (cmd_ff[LANE_STAGES-1]),
      .frame             (frame),
      .tx_id             (tx_id_ff),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_sync_word     (rsp_sync_word),
      .rsp_radio_address (rsp_radio_address),
      .rsp_radio_channel (rsp_radio_channel)
   );

   // A packet leaving the lanes never cuts into the one being emitted
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!status.active || status.at_last))
      else $error("packet loaded while emitter mid-packet");

   // A taken request shows its first byte once it has left the lanes and been loaded into the emitter
   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LANE_STAGES + 1) (rsp_strobe &&
         (rsp_out_byte == DATA_HDR || rsp_out_byte == BIND_HDR)))
      else $error("first packet byte missing");

   // Only one request is in the lanes at a time
   a_one_in_lanes: assert property (@(posedge clock) disable iff (reset)
      $countones(vld_ff) <= 1)
      else $error("overlapping requests in lanes");

   // The last byte is followed by silence unless a load came with it, never a stray beat
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_last_byte |=> (!rsp_strobe || $past(load)))
      else $error("beat after last byte without new packet");

endmodule

`default_nettype wire

// ===== test/rc_link_packet_framer_checker.sv =====
`timescale 1ns / 100ps

module rc_link_packet_framer_checker import rclpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_command,
   input  channel_type req_channel_0,
   input  channel_type req_channel_1,
   input  channel_type req_channel_2,
   input  channel_type req_channel_3,
   input  channel_type req_channel_4,
   input  channel_type req_channel_5,
   input  channel_type req_channel_6,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_byte,
   input  logic [15:0] rsp_sync_word,
   input  logic [7:0]  rsp_radio_address,
   input  logic [7:0]  rsp_radio_channel,
   output int          fail_count,
   output int          bytes_pending
);

   typedef logic [NUM_CHANNELS-1:0][CH_W-1:0] stick_set_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [15:0] sync;
      logic [7:0]  addr;
      logic [7:0]  chan;
   } packet_beat_type;

   packet_beat_type expected_beats[$];
   logic [31:0]     tx_id = TX_ID_RESET;
   int              mismatches = 0;

   // Scale one stick value to 0..SPAN, truncating toward zero
   function automatic logic [VAL_W-1:0] scale_stick(channel_type ch);
      int v;
      v = int'(ch) * SPAN / FULL_SCALE + SPAN;
      if (v < 0) v = 0;
      if (v > SPAN) v = SPAN;
      return v[VAL_W-1:0];
   endfunction

   // Build the packet for one request and queue its bytes as beats
   task automatic queue_packet(input logic cmd, input stick_set_type sticks);
      logic [7:0]       frame [DATA_LEN];
      logic [VAL_W-1:0] val;
      logic [7:0]       xor_all;
      logic [7:0]       xor_head;
      logic [7:0]       hi_sum;
      packet_beat_type  beat;
      int               len;
      int               i;
      if (cmd == CMD_BIND) begin
         frame[0]  = BIND_HDR;
         frame[1]  = BIND_MARK;
         frame[2]  = PKT_VER;
         frame[3]  = PKT_VER;
         frame[4]  = tx_id[31:24];
         frame[5]  = tx_id[23:16];
         frame[6]  = tx_id[15:8];
         frame[7]  = tx_id[7:0];
         frame[8]  = 8'h00;
         frame[9]  = 8'h00;
         frame[10] = BIND_TAIL_HI;
         frame[11] = BIND_TAIL_LO;
         len       = BIND_LEN;
         beat.sync = BIND_SYNC;
         beat.addr = BIND_MARK;
         beat.chan = BIND_MARK;
      end else begin
         frame[0] = DATA_HDR;
         frame[1] = tx_id[23:16];
         frame[2] = PKT_VER;
         for (i = 0; i < NUM_CHANNELS; i++) begin
            val = scale_stick(channel_type'(sticks[i]));
            frame[3 + 2 * i] = 8'(val >> 8);
            frame[4 + 2 * i] = val[7:0];
         end
         // check bytes: two XOR spans and the sum of the first six high bytes
         xor_all  = 8'h00;
         xor_head = 8'h00;
         hi_sum   = 8'h00;
         for (i = 3; i <= 16; i++) begin
            xor_all ^= frame[i];
            if (i <= 14) xor_head ^= frame[i];
         end
         for (i = 3; i <= 13; i += 2) hi_sum += frame[i];
         frame[17] = xor_all;
         frame[18] = xor_head;
         frame[19] = hi_sum;
         len       = DATA_LEN;
         beat.sync = DATA_SYNC;
         beat.addr = tx_id[23:16];
         beat.chan = tx_id[31:24];
      end
      for (i = 0; i < len; i++) begin
         beat.data = frame[i];
         beat.last = (i == len - 1);
         expected_beats.push_back(beat);
      end
   endtask

   // Compare one output beat against the oldest queued byte
   task automatic check_beat();
      packet_beat_type head;
      if (expected_beats.size() == 0) begin
         $error("rsp beat with no packet byte pending: out_byte %02h", rsp_out_byte);
         mismatches++;
      end else begin
         head = expected_beats.pop_front();
         if (rsp_out_byte !== head.data) begin
            $error("out_byte: expected %02h, got %02h", head.data, rsp_out_byte);
            mismatches++;
         end
         if (rsp_last_byte !== head.last) begin
            $error("last_byte: expected %0b, got %0b", head.last, rsp_last_byte);
            mismatches++;
         end
         if (rsp_sync_word !== head.sync) begin
            $error("sync_word: expected %04h, got %04h", head.sync, rsp_sync_word);
            mismatches++;
         end
         if (rsp_radio_address !== head.addr) begin
            $error("radio_address: expected %02h, got %02h", head.addr, rsp_radio_address);
            mismatches++;
         end
         if (rsp_radio_channel !== head.chan) begin
            $error("radio_channel: expected %02h, got %02h", head.chan, rsp_radio_channel);
            mismatches++;
         end
      end
   endtask

   // Watch request, register and output beats at each edge
   always @(posedge clock) begin
      if (reset) begin
         expected_beats.delete();
         tx_id = TX_ID_RESET;
      end else begin
         if (start && !busy) begin
            queue_packet(req_command, {req_channel_6, req_channel_5, req_channel_4,
                                       req_channel_3, req_channel_2, req_channel_1,
                                       req_channel_0});
         end
         if (csr_wr_en) tx_id = csr_wr_data;
         if (rsp_strobe) check_beat();
      end
      fail_count    <= mismatches;
      bytes_pending <= expected_beats.size();
   end

endmodule

// ===== test/tb_rc_link_packet_framer.sv =====
`timescale 1ns / 100ps

module tb_rc_link_packet_framer;
   import rclpf_pkg::*;

   typedef logic [NUM_CHANNELS-1:0][CH_W-1:0] stick_set_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_command;
   channel_type req_channel_0;
   channel_type req_channel_1;
   channel_type req_channel_2;
   channel_type req_channel_3;
   channel_type req_channel_4;
   channel_type req_channel_5;
   channel_type req_channel_6;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic [15:0] rsp_sync_word;
   logic [7:0]  rsp_radio_address;
   logic [7:0]  rsp_radio_channel;
   int          fail_count;
   int          bytes_pending;

   rc_link_packet_framer uut (.*);

   rc_link_packet_framer_checker packet_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic stick_set_type uniform_sticks(int v);
      return {NUM_CHANNELS{CH_W'(v)}};
   endfunction

   // Mix full-range, in-scale, near-boundary and extreme stick values
   function automatic stick_set_type random_sticks();
      stick_set_type s;
      int            v;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         case ($urandom_range(3))
            0: v = int'($urandom_range(65535)) - 32768;
            1: v = int'($urandom_range(2 * FULL_SCALE)) - FULL_SCALE;
            2: begin
               v = ($urandom_range(1) ? FULL_SCALE : 0) + int'($urandom_range(40)) - 20;
               if ($urandom_range(1)) v = -v;
            end
            default: v = $urandom_range(1) ? 32767 : -32768;
         endcase
         s[i] = CH_W'(v);
      end
      return s;
   endfunction

   function automatic logic random_command();
      return ($urandom_range(4) == 0) ? CMD_BIND : CMD_DATA;
   endfunction

   // Present one request and hold it until the block takes it
   task automatic issue_request(input logic cmd, input stick_set_type sticks);
      start       <= 1'b1;
      req_command <= cmd;
      {req_channel_6, req_channel_5, req_channel_4, req_channel_3,
       req_channel_2, req_channel_1, req_channel_0} <= sticks;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a random number of cycles, with junk on the fields
   task automatic pace_sender(int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start       <= 1'b0;
         req_command <= 1'($urandom_range(1));
         {req_channel_6, req_channel_5, req_channel_4, req_channel_3,
          req_channel_2, req_channel_1, req_channel_0} <= random_sticks();
         @(posedge clock);
      end
   endtask

   // Stop sending and wait until every packet byte has come out
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tx_id(logic [31:0] id);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(logic [31:0] id, int idle_pct, int count);
      wait_for_drain();
      write_tx_id(id);
      repeat (count) begin
         pace_sender(idle_pct);
         issue_request(random_command(), random_sticks());
      end
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_command <= CMD_DATA;
      {req_channel_6, req_channel_5, req_channel_4, req_channel_3,
       req_channel_2, req_channel_1, req_channel_0} <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: scale extremes, saturation, truncation toward zero, bind
      issue_request(CMD_DATA, uniform_sticks(0));
      issue_request(CMD_DATA, uniform_sticks(FULL_SCALE));
      issue_request(CMD_DATA, uniform_sticks(-FULL_SCALE));
      issue_request(CMD_DATA, uniform_sticks(32767));
      issue_request(CMD_DATA, uniform_sticks(-32768));
      issue_request(CMD_DATA, uniform_sticks(1));
      issue_request(CMD_DATA, uniform_sticks(-1));
      issue_request(CMD_DATA, uniform_sticks(15));
      issue_request(CMD_DATA, uniform_sticks(-15));
      issue_request(CMD_DATA, uniform_sticks(-16));
      issue_request(CMD_DATA, {CH_W'(5000), CH_W'(-16), CH_W'(16), CH_W'(-10001),
                               CH_W'(10001), CH_W'(-9999), CH_W'(9999)});
      // Bind after data: the stale tail of the data packet must not leak out
      issue_request(CMD_BIND, uniform_sticks(0));
      issue_request(CMD_BIND, uniform_sticks(32767));
      issue_request(CMD_DATA, {CH_W'(10000), CH_W'(6667), CH_W'(3333), CH_W'(0),
                               CH_W'(-3333), CH_W'(-6667), CH_W'(-10000)});
      issue_request(CMD_DATA, {CH_W'(10000), CH_W'(-10000), CH_W'(1), CH_W'(0),
                               CH_W'(-1), CH_W'(32767), CH_W'(-32768)});
      issue_request(CMD_DATA, uniform_sticks(16'sh5555));
      issue_request(CMD_DATA, uniform_sticks(-21846));
      issue_request(CMD_BIND, random_sticks());
      issue_request(CMD_DATA, random_sticks());
      issue_request(CMD_BIND, random_sticks());

      // Random: sweep the transmitter id through its extremes and idle rates
      run_phase(32'h0000_0000, 0, 40);
      run_phase(32'hffff_ffff, 45, 40);
      run_phase($urandom, 0, 40);
      run_phase($urandom, 11, 40);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
